### design/mbn_pkg.sv
`default_nettype none

package mbn_pkg;

  localparam int MaxChannels  = 8;
  localparam int SampleBits   = 24;
  localparam int CoefFracBits = 24;

  localparam int CoefBits     = 27;
  localparam int CfgIdxBits   = 3;
  localparam int CfgDataBits  = 27;
  localparam int ChanCfgBits  = 4;
  localparam int ChanIdxBits  = 3;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_CHANNELS = 3'd0,
    CFG_COEF_B0  = 3'd1,
    CFG_COEF_B1  = 3'd2,
    CFG_COEF_B2  = 3'd3,
    CFG_COEF_A1  = 3'd4,
    CFG_COEF_A2  = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic signed [CoefBits-1:0] b0;
    logic signed [CoefBits-1:0] b1;
    logic signed [CoefBits-1:0] b2;
    logic signed [CoefBits-1:0] a1;
    logic signed [CoefBits-1:0] a2;
  } coef_t;

  localparam logic signed [CoefBits-1:0] CoefOne = CoefBits'(1 << CoefFracBits);

endpackage

`default_nettype wire

### design/mbn_chan_seq.sv
`default_nettype none

module mbn_chan_seq #(
  parameter int MAX_CHANNELS = mbn_pkg::MaxChannels,
  parameter int CW           = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             accept_i,
  input  wire logic                             buffer_start_i,
  input  wire logic [mbn_pkg::ChanCfgBits-1:0]  chans_i,
  output logic      [CW-1:0]                    ch_o
);
  import mbn_pkg::*;

  localparam int NW = $clog2(MAX_CHANNELS + 1);
  localparam int EW = (NW > ChanCfgBits) ? NW : ChanCfgBits;

  logic [CW-1:0] cnt_q, cnt_d;
  logic [EW-1:0] chans_ext, eff, base, ch_ext, inc, nxt;

  always_comb begin
    chans_ext = EW'(chans_i);
    if (chans_ext == '0) begin
      eff = EW'(1);
    end else if (chans_ext > EW'(MAX_CHANNELS)) begin
      eff = EW'(MAX_CHANNELS);
    end else begin
      eff = chans_ext;
    end
    base   = buffer_start_i ? '0 : EW'(cnt_q);
    ch_ext = (base >= eff) ? '0 : base;
    inc    = ch_ext + EW'(1);
    nxt    = (inc >= eff) ? '0 : inc;
    cnt_d  = accept_i ? CW'(nxt) : cnt_q;
    ch_o   = CW'(ch_ext);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // assigned channel always lies inside the active channel count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i |-> (ch_ext < eff))
    else $error("channel outside active count");

endmodule

`default_nettype wire

### design/mbn_history.sv
`default_nettype none

module mbn_history #(
  parameter int MAX_CHANNELS = mbn_pkg::MaxChannels,
  parameter int SAMPLE_BITS  = mbn_pkg::SampleBits,
  parameter int CW           = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          we_i,
  input  wire logic                          clr_i,
  input  wire logic        [CW-1:0]          ch_i,
  input  wire logic signed [SAMPLE_BITS-1:0] x_i,
  input  wire logic signed [SAMPLE_BITS-1:0] y_i,
  output logic signed      [SAMPLE_BITS-1:0] x1_o,
  output logic signed      [SAMPLE_BITS-1:0] x2_o,
  output logic signed      [SAMPLE_BITS-1:0] y1_o,
  output logic signed      [SAMPLE_BITS-1:0] y2_o
);
  import mbn_pkg::*;

  logic [SAMPLE_BITS-1:0] x1_q [MAX_CHANNELS];
  logic [SAMPLE_BITS-1:0] x2_q [MAX_CHANNELS];
  logic [SAMPLE_BITS-1:0] y1_q [MAX_CHANNELS];
  logic [SAMPLE_BITS-1:0] y2_q [MAX_CHANNELS];

  // a clear makes every history read as zero for the transaction that carries it
  always_comb begin
    x1_o = clr_i ? '0 : x1_q[ch_i];
    x2_o = clr_i ? '0 : x2_q[ch_i];
    y1_o = clr_i ? '0 : y1_q[ch_i];
    y2_o = clr_i ? '0 : y2_q[ch_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        x1_q[i] <= '0;
        x2_q[i] <= '0;
        y1_q[i] <= '0;
        y2_q[i] <= '0;
      end
    end else if (we_i) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        if (CW'(i) == ch_i) begin
          x2_q[i] <= x1_o;
          x1_q[i] <= x_i;
          y2_q[i] <= y1_o;
          y1_q[i] <= y_i;
        end else if (clr_i) begin
          x1_q[i] <= '0;
          x2_q[i] <= '0;
          y1_q[i] <= '0;
          y2_q[i] <= '0;
        end
      end
    end
  end

  // a clear leaves channel zero empty unless it took the sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we_i && clr_i && (ch_i != '0)) |=> (x1_q[0] == '0 && y1_q[0] == '0))
    else $error("history not cleared");

endmodule

`default_nettype wire

### design/mbn_mac.sv
`default_nettype none

module mbn_mac #(
  parameter int SAMPLE_BITS    = mbn_pkg::SampleBits,
  parameter int COEF_FRAC_BITS = mbn_pkg::CoefFracBits
) (
  input  wire mbn_pkg::coef_t                coef_i,
  input  wire logic signed [SAMPLE_BITS-1:0] x_i,
  input  wire logic signed [SAMPLE_BITS-1:0] x1_i,
  input  wire logic signed [SAMPLE_BITS-1:0] x2_i,
  input  wire logic signed [SAMPLE_BITS-1:0] y1_i,
  input  wire logic signed [SAMPLE_BITS-1:0] y2_i,
  output logic signed      [SAMPLE_BITS-1:0] y_o,
  output logic                               clip_o
);
  import mbn_pkg::*;

  localparam int AW = SAMPLE_BITS + CoefBits + 3;
  localparam logic signed [AW-1:0] SatHi = AW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [AW-1:0] SatLo = -SatHi - AW'(1);
  localparam logic signed [AW-1:0] Half  = AW'(64'sd1 <<< (COEF_FRAC_BITS - 1));

  logic signed [AW-1:0] p0, p1, p2, p3, p4;
  logic signed [AW-1:0] acc, scaled;
  logic                 over, under;

  always_comb begin
    p0     = AW'(coef_i.b0) * AW'(x_i);
    p1     = AW'(coef_i.b1) * AW'(x1_i);
    p2     = AW'(coef_i.b2) * AW'(x2_i);
    p3     = AW'(coef_i.a1) * AW'(y1_i);
    p4     = AW'(coef_i.a2) * AW'(y2_i);
    acc    = p0 + p1 + p2 - p3 - p4;
    // round half up, then floor shift
    scaled = (acc + Half) >>> COEF_FRAC_BITS;
    over   = scaled > SatHi;
    under  = scaled < SatLo;
    clip_o = over | under;
    if (over) begin
      y_o = SAMPLE_BITS'(SatHi);
    end else if (under) begin
      y_o = SAMPLE_BITS'(SatLo);
    end else begin
      y_o = SAMPLE_BITS'(scaled);
    end
  end

endmodule

`default_nettype wire

### design/multichannel_biquad_notch.sv
`default_nettype none

// channel   handshake                     payload
// input     in_valid_i / in_ready_o       sample_in_i, buffer_start_i, clear_history_i
// output    out_valid_o / out_ready_i     sample_out_o, channel_index_o, status_o
// config    cfg_we_i (no wait)            cfg_idx_i, cfg_wdata_i
//
// one transaction per cycle while the result is not stalled; a taken input goes through the
// input register, five multipliers and the round/saturate stage, then the result register
// per-channel history is written as the result is registered, so back-to-back
// samples on one channel see each other
// reset zeroes all histories, the channel counter and loads default coefficients
// a stalled result holds the pipe; input is taken while the input register can move

module multichannel_biquad_notch #(
  parameter int MAX_CHANNELS   = mbn_pkg::MaxChannels,
  parameter int SAMPLE_BITS    = mbn_pkg::SampleBits,
  parameter int COEF_FRAC_BITS = mbn_pkg::CoefFracBits
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [mbn_pkg::CfgIdxBits-1:0]     cfg_idx_i,
  input  wire logic [mbn_pkg::CfgDataBits-1:0]    cfg_wdata_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic signed [SAMPLE_BITS-1:0]      sample_in_i,
  input  wire logic                               buffer_start_i,
  input  wire logic                               clear_history_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]           sample_out_o,
  output logic        [mbn_pkg::ChanIdxBits-1:0]  channel_index_o,
  output logic                                    status_o
);
  import mbn_pkg::*;

  localparam int CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic [ChanCfgBits-1:0] chans_q;
  coef_t                  coef_q;

  logic                          s1_valid_q;
  logic signed [SAMPLE_BITS-1:0] s1_x_q;
  logic [CW-1:0]                 s1_ch_q;
  logic                          s1_clr_q;

  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] out_y_q;
  logic [ChanIdxBits-1:0]        out_ch_q;
  logic                          out_clip_q;

  logic                          accept, adv;
  logic [CW-1:0]                 ch;
  logic signed [SAMPLE_BITS-1:0] x1, x2, y1, y2, y;
  logic                          clip;

  assign adv        = s1_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~s1_valid_q | adv;
  assign accept     = in_valid_i & in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chans_q   <= ChanCfgBits'(1);
      coef_q.b0 <= CoefOne;
      coef_q.b1 <= '0;
      coef_q.b2 <= '0;
      coef_q.a1 <= '0;
      coef_q.a2 <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CHANNELS: chans_q   <= cfg_wdata_i[ChanCfgBits-1:0];
        CFG_COEF_B0:  coef_q.b0 <= cfg_wdata_i[CoefBits-1:0];
        CFG_COEF_B1:  coef_q.b1 <= cfg_wdata_i[CoefBits-1:0];
        CFG_COEF_B2:  coef_q.b2 <= cfg_wdata_i[CoefBits-1:0];
        CFG_COEF_A1:  coef_q.a1 <= cfg_wdata_i[CoefBits-1:0];
        CFG_COEF_A2:  coef_q.a2 <= cfg_wdata_i[CoefBits-1:0];
        default: ;
      endcase
    end
  end

  mbn_chan_seq #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .CW           (CW)
  ) u_chan_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .buffer_start_i (buffer_start_i),
    .chans_i        (chans_q),
    .ch_o           (ch)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_x_q   <= sample_in_i;
      s1_ch_q  <= ch;
      s1_clr_q <= buffer_start_i & clear_history_i;
    end
  end

  mbn_history #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .SAMPLE_BITS  (SAMPLE_BITS),
    .CW           (CW)
  ) u_history (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (adv),
    .clr_i  (s1_clr_q),
    .ch_i   (s1_ch_q),
    .x_i    (s1_x_q),
    .y_i    (y),
    .x1_o   (x1),
    .x2_o   (x2),
    .y1_o   (y1),
    .y2_o   (y2)
  );

  mbn_mac #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_mac (
    .coef_i (coef_q),
    .x_i    (s1_x_q),
    .x1_i   (x1),
    .x2_i   (x2),
    .y1_i   (y1),
    .y2_i   (y2),
    .y_o    (y),
    .clip_o (clip)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_y_q    <= y;
      out_ch_q   <= ChanIdxBits'(s1_ch_q);
      out_clip_q <= clip;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sample_out_o    = out_y_q;
  assign channel_index_o = out_ch_q;
  assign status_o        = out_clip_q;

  // a sample leaving the input register always lands in the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_q)
    else $error("result lost");

  // input is refused only while the input register holds a stalled sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && out_valid_q && !out_ready_i))
    else $error("input refused without a stall");

endmodule

`default_nettype wire

### tb/tb_multichannel_biquad_notch.sv
`default_nettype none

module tb_multichannel_biquad_notch;
  import mbn_pkg::*;

  localparam logic StatusOk      = 1'b0;
  localparam logic StatusClipped = 1'b1;
  localparam longint SatHi = (longint'(1) <<< (SampleBits - 1)) - 1;
  localparam longint SatLo = -SatHi - 1;
  localparam logic signed [SampleBits-1:0] SampleMax = SatHi[SampleBits-1:0];
  localparam logic signed [SampleBits-1:0] SampleMin = SatLo[SampleBits-1:0];
  localparam logic signed [CoefBits-1:0] CoefMax = {1'b0, {(CoefBits - 1){1'b1}}};
  localparam logic signed [CoefBits-1:0] CoefMin = {1'b1, {(CoefBits - 1){1'b0}}};
  localparam int unsigned RandomPhases = 8;
  localparam int unsigned PhaseItems = 175;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned ReportLimit = 10;

  typedef enum int unsigned {
    COEF_WILD,
    COEF_NOTCH,
    COEF_MILD
  } coef_style_e;

  typedef struct {
    logic signed [SampleBits-1:0] sample;
    logic [ChanIdxBits-1:0]       chan;
    logic                         clipped;
  } filt_result_t;

  class biquad_scoreboard;
    logic [ChanCfgBits-1:0]       chans_cfg;
    coef_t                        coefs;
    int unsigned                  chan_ptr;
    logic signed [SampleBits-1:0] x_one [MaxChannels];
    logic signed [SampleBits-1:0] x_two [MaxChannels];
    logic signed [SampleBits-1:0] y_one [MaxChannels];
    logic signed [SampleBits-1:0] y_two [MaxChannels];
    filt_result_t                 pending_outputs [$];
    int unsigned                  failures;

    function new();
      chans_cfg = 1;
      coefs.b0 = CoefOne;
      coefs.b1 = '0;
      coefs.b2 = '0;
      coefs.a1 = '0;
      coefs.a2 = '0;
      chan_ptr = 0;
      failures = 0;
      clear_histories();
    endfunction

    function void clear_histories();
      for (int c = 0; c < MaxChannels; c++) begin
        x_one[c] = '0;
        x_two[c] = '0;
        y_one[c] = '0;
        y_two[c] = '0;
      end
    endfunction

    function void write_reg(cfg_reg_e idx, logic [CfgDataBits-1:0] data);
      case (idx)
        CFG_CHANNELS: chans_cfg = data[ChanCfgBits-1:0];
        CFG_COEF_B0: coefs.b0 = data[CoefBits-1:0];
        CFG_COEF_B1: coefs.b1 = data[CoefBits-1:0];
        CFG_COEF_B2: coefs.b2 = data[CoefBits-1:0];
        CFG_COEF_A1: coefs.a1 = data[CoefBits-1:0];
        CFG_COEF_A2: coefs.a2 = data[CoefBits-1:0];
        default: ;
      endcase
    endfunction

    function void take_sample(logic signed [SampleBits-1:0] x, logic start, logic clr);
      int unsigned  eff;
      int unsigned  ch;
      longint       acc;
      longint       y;
      filt_result_t r;
      eff = (chans_cfg == 0) ? 1 : ((chans_cfg > MaxChannels) ? MaxChannels : chans_cfg);
      if (start) begin
        if (clr) begin
          clear_histories();
        end
        chan_ptr = 0;
      end
      if (chan_ptr >= eff) begin
        chan_ptr = 0;
      end
      ch = chan_ptr;
      acc = longint'($signed(coefs.b0)) * longint'(x)
          + longint'($signed(coefs.b1)) * longint'(x_one[ch])
          + longint'($signed(coefs.b2)) * longint'(x_two[ch])
          - longint'($signed(coefs.a1)) * longint'(y_one[ch])
          - longint'($signed(coefs.a2)) * longint'(y_two[ch]);
      y = (acc + (longint'(1) <<< (CoefFracBits - 1))) >>> CoefFracBits;
      r.clipped = StatusOk;
      if (y > SatHi) begin
        y = SatHi;
        r.clipped = StatusClipped;
      end
      if (y < SatLo) begin
        y = SatLo;
        r.clipped = StatusClipped;
      end
      r.sample = y[SampleBits-1:0];
      r.chan = ch[ChanIdxBits-1:0];
      x_two[ch] = x_one[ch];
      x_one[ch] = x;
      y_two[ch] = y_one[ch];
      y_one[ch] = r.sample;
      chan_ptr = ch + 1;
      if (chan_ptr >= eff) begin
        chan_ptr = 0;
      end
      pending_outputs.push_back(r);
    endfunction

    function void compare_output(logic signed [SampleBits-1:0] s, logic [ChanIdxBits-1:0] ch,
                                 logic st);
      filt_result_t e;
      if (pending_outputs.size() == 0) begin
        failures++;
        if (failures <= ReportLimit) begin
          $display("unexpected transaction: sample %0d channel %0d status %0b", s, ch, st);
        end
        return;
      end
      e = pending_outputs.pop_front();
      if (s !== e.sample || ch !== e.chan || st !== e.clipped) begin
        failures++;
        if (failures <= ReportLimit) begin
          $display("mismatch: expected sample %0d channel %0d status %0b, got %0d %0d %0b",
                   e.sample, e.chan, e.clipped, s, ch, st);
        end
      end
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic [CfgIdxBits-1:0]         cfg_idx_i = CFG_CHANNELS;
  logic [CfgDataBits-1:0]        cfg_wdata_i = '0;
  logic                          in_valid_i = 1'b0;
  logic                          in_ready_o;
  logic signed [SampleBits-1:0]  sample_in_i = '0;
  logic                          buffer_start_i = 1'b0;
  logic                          clear_history_i = 1'b0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic signed [SampleBits-1:0]  sample_out_o;
  logic [ChanIdxBits-1:0]        channel_index_o;
  logic                          status_o;

  logic steady_flow = 1'b0;
  biquad_scoreboard sb = new();

  multichannel_biquad_notch DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sample_in_i    (sample_in_i),
    .buffer_start_i (buffer_start_i),
    .clear_history_i(clear_history_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .sample_out_o   (sample_out_o),
    .channel_index_o(channel_index_o),
    .status_o       (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        sb.compare_output(sample_out_o, channel_index_o, status_o);
      end
      out_ready_i <= steady_flow || ($urandom_range(99) >= 12);
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("== FAIL ==");
    $finish;
  end

  task automatic send_sample(input logic signed [SampleBits-1:0] x, input logic start,
                             input logic clr);
    if (!steady_flow && $urandom_range(99) < 12) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_in_i <= x;
    buffer_start_i <= start;
    clear_history_i <= clr;
    do @(posedge clk_i); while (!in_ready_o);
    sb.take_sample(x, start, clr);
  endtask

  // hold off until every result is back, then let the pipe settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_outputs.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apply_settings(input logic [ChanCfgBits-1:0] chans, input coef_t c);
    cfg_reg_e               r;
    logic [CfgDataBits-1:0] v;
    r = r.first();
    repeat (r.num()) begin
      case (r)
        CFG_CHANNELS: v = CfgDataBits'(chans);
        CFG_COEF_B0: v = c.b0;
        CFG_COEF_B1: v = c.b1;
        CFG_COEF_B2: v = c.b2;
        CFG_COEF_A1: v = c.a1;
        CFG_COEF_A2: v = c.a2;
        default: v = '0;
      endcase
      cfg_we_i <= 1'b1;
      cfg_idx_i <= r;
      cfg_wdata_i <= v;
      @(posedge clk_i);
      sb.write_reg(r, v);
      r = r.next();
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic coef_t random_coefs(coef_style_e style);
    coef_t c;
    int    k;
    case (style)
      COEF_NOTCH: begin
        k = int'($urandom_range(0, 1 << 26)) - (1 << 25);
        c.b0 = CoefBits'($urandom_range(1 << 23, 1 << 24));
        c.b1 = CoefBits'(k);
        c.b2 = c.b0;
        c.a1 = CoefBits'((k * 15) / 16);
        c.a2 = CoefBits'($urandom_range(12000000, 16000000));
      end
      COEF_MILD: begin
        c.b0 = CoefBits'(int'($urandom_range(0, 1 << 24)) - (1 << 23));
        c.b1 = CoefBits'(int'($urandom_range(0, 1 << 24)) - (1 << 23));
        c.b2 = CoefBits'(int'($urandom_range(0, 1 << 24)) - (1 << 23));
        c.a1 = CoefBits'(int'($urandom_range(0, 1 << 24)) - (1 << 23));
        c.a2 = CoefBits'(int'($urandom_range(0, 1 << 24)) - (1 << 23));
      end
      default: begin
        c.b0 = CoefBits'($urandom);
        c.b1 = CoefBits'($urandom);
        c.b2 = CoefBits'($urandom);
        c.a1 = CoefBits'($urandom);
        c.a2 = CoefBits'($urandom);
      end
    endcase
    return c;
  endfunction

  initial begin
    coef_t                        c;
    coef_style_e                  style;
    logic [ChanCfgBits-1:0]       chans;
    int unsigned                  eff;
    int unsigned                  len;
    int unsigned                  sent;
    logic                         start;
    logic                         clr;
    logic signed [SampleBits-1:0] x;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: single channel, unity pass-through
    send_sample(SampleMax, 1'b0, 1'b0);
    send_sample(SampleMin, 1'b0, 1'b0);
    send_sample(-1, 1'b0, 1'b0);

    // extreme coefficients drive both rails
    drain();
    c.b0 = CoefMax;
    c.b1 = CoefMin;
    c.b2 = CoefMax;
    c.a1 = CoefMin;
    c.a2 = CoefMax;
    apply_settings(2, c);
    send_sample(SampleMax, 1'b1, 1'b1);
    send_sample(SampleMin, 1'b0, 1'b0);
    send_sample(SampleMax, 1'b0, 1'b0);
    send_sample(SampleMin, 1'b0, 1'b0);
    send_sample(SampleMax, 1'b0, 1'b0);

    // notch, clear with start, clear without start, then fewer channels mid-buffer
    drain();
    c.b0 = 15938355;
    c.b1 = -30000000;
    c.b2 = 15938355;
    c.a1 = -28500000;
    c.a2 = 15099494;
    apply_settings(8, c);
    send_sample(1000000, 1'b1, 1'b1);
    send_sample(-2000000, 1'b0, 1'b0);
    send_sample(3000000, 1'b0, 1'b0);
    send_sample(SampleMax, 1'b0, 1'b1);
    send_sample(SampleMin, 1'b0, 1'b0);
    drain();
    apply_settings(3, c);
    send_sample(12345, 1'b0, 1'b0);
    send_sample(-1, 1'b1, 1'b0);

    // zero channels and too many channels
    drain();
    apply_settings(0, c);
    send_sample(500000, 1'b1, 1'b0);
    send_sample(600000, 1'b0, 1'b0);
    drain();
    apply_settings(15, c);
    for (int i = 0; i < 9; i++) begin
      send_sample(SampleBits'($urandom), i == 0, i == 0);
    end

    for (int p = 0; p < RandomPhases; p++) begin
      drain();
      steady_flow = (p == 2);
      style = coef_style_e'($urandom_range(0, 2));
      if (p == 0) begin
        chans = 1;
      end else if (p == 1) begin
        chans = MaxChannels;
      end else if ($urandom_range(3) == 0) begin
        chans = ChanCfgBits'($urandom_range(0, 15));
      end else begin
        chans = ChanCfgBits'($urandom_range(1, MaxChannels));
      end
      apply_settings(chans, random_coefs(style));
      eff = (chans == 0) ? 1 : ((chans > MaxChannels) ? MaxChannels : chans);
      sent = 0;
      while (sent < PhaseItems) begin
        len = eff * $urandom_range(1, 6);
        for (int i = 0; i < len && sent < PhaseItems; i++) begin
          start = (i == 0);
          clr = (i == 0) && ($urandom_range(3) == 0);
          if ($urandom_range(99) < 8) begin
            start = 1'($urandom_range(1));
            clr = 1'($urandom_range(1));
          end
          if ($urandom_range(3) == 0) begin
            x = SampleBits'(int'($urandom_range(0, 2000)) - 1000);
          end else begin
            x = SampleBits'($urandom);
          end
          send_sample(x, start, clr);
          sent++;
        end
      end
      steady_flow = 1'b0;
    end

    drain();
    if (sb.failures == 0 && sb.pending_outputs.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

### files.f
design/mbn_pkg.sv
design/mbn_chan_seq.sv
design/mbn_history.sv
design/mbn_mac.sv
design/multichannel_biquad_notch.sv
tb/tb_multichannel_biquad_notch.sv
